// ===== rtl/rhc_pkg.sv =====
package rhc_pkg;

  // Component width and fixed-point scales
  localparam int CompBits = 8;
  localparam int SatShift = 12;
  localparam int SatOne   = 1 << SatShift;
  localparam int SatBits  = 13;
  localparam int HueBits  = 15;
  localparam int HueSixth = 3840;
  localparam int HueFull  = 23040;

  // Divider: both quotients fit in QuoBits (sat <= 4096, hue part <= 3840)
  localparam int QuoBits  = 13;
  localparam int NumBits  = CompBits + SatShift;

  // Hue sector, picked by the first component equal to max (red, green, blue)
  typedef enum logic [1:0] {
    SecRed   = 2'd0,
    SecGreen = 2'd1,
    SecBlue  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [CompBits-1:0] red;
    logic [CompBits-1:0] green;
    logic [CompBits-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [HueBits-1:0]  hue;
    logic [SatBits-1:0]  saturation;
    logic [CompBits-1:0] value;
  } pix_out_t;

  // One lane of the restoring divider: partial remainder, numerator bits
  // not yet shifted in, quotient bits so far
  typedef struct packed {
    logic [CompBits-1:0] rem;
    logic [QuoBits-1:0]  num;
    logic [QuoBits-1:0]  quo;
  } div_lane_t;

  // Beat carried through the divider stages
  typedef struct packed {
    sector_e             sector;
    logic                gray;
    logic                neg;
    logic [CompBits-1:0] value;
    logic [CompBits-1:0] delta;
    div_lane_t           sat;
    div_lane_t           hue;
  } pipe_t;

endpackage

// ===== rtl/rgb_to_hsv_converter_unit.sv =====
// Channel  Direction  Handshake                 Beat
// -------  ---------  ------------------------  ---------------------------
// in       input      in_valid_i / in_stall_o   pix_in_t  (red, green, blue)
// out      output     out_valid_o / out_stall_i pix_out_t (hue, saturation, value)
//
// One pixel per clock while out_stall_i is low. Stages: two front stages (max/min,
// then delta and divider load), 13 restoring divider stages (one quotient
// bit each for saturation and hue in parallel), one output register.
// Reset clears the valid bits only; payload registers are not reset.
// Stall backs up stage by stage; empty stages still fill, so beats are
// accepted while a result waits until the pipeline is full.
module rgb_to_hsv_converter_unit import rhc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  pix_in_t  in_data_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  output pix_out_t out_data_o,
  input  logic     out_stall_i
);

  logic  front_ready;
  logic  div_valid [QuoBits+1];
  logic  div_ready [QuoBits+1];
  pipe_t div_data  [QuoBits+1];

  assign in_stall_o = !front_ready;

  rhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .ready_o (front_ready),
    .valid_o (div_valid[0]),
    .data_o  (div_data[0]),
    .ready_i (div_ready[0])
  );

  // Divider chain, one quotient bit per stage
  for (genvar k = 0; k < QuoBits; k++) begin : g_div
    rhc_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[k]),
      .data_i  (div_data[k]),
      .ready_o (div_ready[k]),
      .valid_o (div_valid[k+1]),
      .data_o  (div_data[k+1]),
      .ready_i (div_ready[k+1])
    );
  end

  rhc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid[QuoBits]),
    .data_i  (div_data[QuoBits]),
    .ready_o (div_ready[QuoBits]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o),
    .stall_i (out_stall_i)
  );

endmodule

// ===== rtl/rhc_front.sv =====
module rhc_front import rhc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  pix_in_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  output pipe_t   data_o,
  input  logic    ready_i
);

  typedef struct packed {
    logic [CompBits-1:0] r;
    logic [CompBits-1:0] g;
    logic [CompBits-1:0] b;
    logic [CompBits-1:0] mx;
    logic [CompBits-1:0] mn;
    sector_e             sector;
  } s1_t;

  logic  s1_valid_q, s2_valid_q;
  logic  s1_ready, s2_ready;
  s1_t   s1_d, s1_q;
  pipe_t s2_d, s2_q;

  logic signed [CompBits:0] diff;
  logic signed [CompBits:0] ndiff;
  logic [CompBits-1:0]      absd;
  logic [NumBits-1:0]       sat_num;
  logic [NumBits-1:0]       hue_num;

  // Stage handshake: a stage takes a beat when empty or when it drains
  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;
  assign valid_o  = s2_valid_q;
  assign data_o   = s2_q;

  // Stage 1: max, min, sector
  always_comb begin
    s1_d.r  = data_i.red;
    s1_d.g  = data_i.green;
    s1_d.b  = data_i.blue;
    s1_d.mx = data_i.red;
    s1_d.mn = data_i.red;
    if (data_i.green > s1_d.mx) s1_d.mx = data_i.green;
    if (data_i.blue  > s1_d.mx) s1_d.mx = data_i.blue;
    if (data_i.green < s1_d.mn) s1_d.mn = data_i.green;
    if (data_i.blue  < s1_d.mn) s1_d.mn = data_i.blue;
    if (data_i.red == s1_d.mx) begin
      s1_d.sector = SecRed;
    end else if (data_i.green == s1_d.mx) begin
      s1_d.sector = SecGreen;
    end else begin
      s1_d.sector = SecBlue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: delta, signed difference, magnitudes, divider load
  always_comb begin
    case (s1_q.sector)
      SecGreen: diff = $signed({1'b0, s1_q.b}) - $signed({1'b0, s1_q.r});
      SecBlue:  diff = $signed({1'b0, s1_q.r}) - $signed({1'b0, s1_q.g});
      default:  diff = $signed({1'b0, s1_q.g}) - $signed({1'b0, s1_q.b});
    endcase
    ndiff = -diff;
    absd  = diff[CompBits] ? ndiff[CompBits-1:0] : diff[CompBits-1:0];

    s2_d.sector = s1_q.sector;
    s2_d.value  = s1_q.mx;
    s2_d.delta  = s1_q.mx - s1_q.mn;
    s2_d.gray   = (s2_d.delta == '0);
    s2_d.neg    = diff[CompBits];

    sat_num = NumBits'(s2_d.delta) << SatShift;
    hue_num = NumBits'(absd) * NumBits'(HueSixth);

    // Quotients stay below 2**QuoBits, so the top bits are already below the divisor
    s2_d.sat.rem = CompBits'(sat_num >> QuoBits);
    s2_d.sat.num = sat_num[QuoBits-1:0];
    s2_d.sat.quo = '0;
    s2_d.hue.rem = CompBits'(hue_num >> QuoBits);
    s2_d.hue.num = hue_num[QuoBits-1:0];
    s2_d.hue.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  // Min never exceeds max in a live beat
  a_minmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_q.mn <= s1_q.mx))
    else $error("rhc_front: min above max");

endmodule

// ===== rtl/rhc_div_stage.sv =====
module rhc_div_stage import rhc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  pipe_t data_i,
  output logic  ready_o,
  output logic  valid_o,
  output pipe_t data_o,
  input  logic  ready_i
);

  logic  valid_q;
  pipe_t data_d, data_q;

  // One restoring step: shift in a numerator bit, subtract if it fits
  function automatic div_lane_t div_step(div_lane_t lane, logic [CompBits-1:0] dvsr);
    div_lane_t           res;
    logic [CompBits:0]   shifted;
    logic [CompBits:0]   trial;
    logic                qbit;
    shifted = {lane.rem, lane.num[QuoBits-1]};
    trial   = shifted - {1'b0, dvsr};
    qbit    = (shifted >= {1'b0, dvsr});
    res.rem = qbit ? trial[CompBits-1:0] : shifted[CompBits-1:0];
    res.num = {lane.num[QuoBits-2:0], 1'b0};
    res.quo = {lane.quo[QuoBits-2:0], qbit};
    return res;
  endfunction

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Saturation divides by max, hue by delta
  always_comb begin
    data_d     = data_i;
    data_d.sat = div_step(data_i.sat, data_i.value);
    data_d.hue = div_step(data_i.hue, data_i.delta);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  // Partial remainders stay below their divisors
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !data_q.gray) |->
      ((data_q.sat.rem < data_q.value) && (data_q.hue.rem < data_q.delta)))
    else $error("rhc_div_stage: remainder not below divisor");

endmodule

// ===== rtl/rhc_back.sv =====
module rhc_back import rhc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  pipe_t    data_i,
  output logic     ready_o,
  output logic     valid_o,
  output pix_out_t data_o,
  input  logic     stall_i
);

  logic               valid_q;
  pix_out_t           data_d, data_q;
  logic [HueBits-1:0] base;
  logic [HueBits-1:0] top;
  logic [HueBits-1:0] quo;

  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Hue assembly: sector base plus signed quotient, wrapped into one turn
  always_comb begin
    case (data_i.sector)
      SecGreen: base = HueBits'(2 * HueSixth);
      SecBlue:  base = HueBits'(4 * HueSixth);
      default:  base = '0;
    endcase
    quo = HueBits'(data_i.hue.quo);
    // negative red-sector hue wraps; a quotient that truncates to zero stays 0
    top = (data_i.sector == SecRed && quo != '0) ? HueBits'(HueFull) : base;

    data_d.value = data_i.value;
    if (data_i.gray) begin
      data_d.hue        = '0;
      data_d.saturation = '0;
    end else begin
      data_d.hue        = data_i.neg ? (top - quo) : (base + quo);
      data_d.saturation = SatBits'(data_i.sat.quo);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (data_q.saturation <= SatBits'(SatOne)))
    else $error("rhc_back: saturation above one");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (data_q.hue < HueBits'(HueFull)))
    else $error("rhc_back: hue beyond full turn");

  // Zero saturation only happens on gray pixels, whose hue is zero
  a_gray_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && data_q.saturation == '0) |-> (data_q.hue == '0))
    else $error("rhc_back: unsaturated pixel with nonzero hue");

endmodule
